// ===== hw/rtl/sha_bsh_pkg.sv =====
// Shared types and constants for the SHA-256 byte stream hasher.
// No dependencies; imported by sha_bsh_core and the top level.
package sha_bsh_pkg;

    typedef logic [7:0][31:0] t_hash;

    // Command from the sequencer to the compression unit.
    typedef struct packed {
        logic       shift;  // shift one byte into the block register
        logic [7:0] data;   // the byte to shift in
        logic       start;  // begin a 64-round compression
        logic       init;   // reload the initial hash values
    } t_core_cmd;

    // Status from the compression unit back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

    localparam logic [31:0] SHA_H0 [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

// ===== hw/rtl/sha256_byte_stream_hasher.sv =====
// Top level of the SHA-256 byte stream hasher: request handshakes, byte counting,
// padding sequencer and digest output. Depends on sha_bsh_pkg and sha_bsh_core.
//
//   Channel   Direction  Handshake            Payload
//   input     in         i_valid / o_ready    i_data_byte, i_has_byte, i_end_of_message
//   output    out        o_valid / i_ready    o_digest_word, o_word_index, o_digest_last
//
// A request that carries a byte shifts it into the block register; the 64th byte of a
// block starts the compression unit, which runs one round a cycle through all rounds,
// adds the working variables into the hash in its fold state and hands back in the
// next. An end-of-message request then shifts in one padding byte a cycle up to the
// end of the block (and a whole extra block when the length no longer fits), runs one
// or two compressions and ends with four output requests. Reset is synchronous and
// active low; it loads the initial hash and clears the counters. No input is taken while
// a block is compressed, padded or the digest is offered; a stalled output simply holds.
module sha256_byte_stream_hasher
    import sha_bsh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_digest_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMP,
        S_PAD,
        S_OUT
    } t_state;

    t_state      r_state, n_state;
    logic [5:0]  r_fill, n_fill;     // bytes held in the current block
    logic [63:0] r_bits, n_bits;     // message length in bits, wraps at 2^64
    logic        r_eom, n_eom;       // message ended with the byte that filled a block
    logic        r_mark, n_mark;     // the 0x80 marker has been placed
    logic        r_len, n_len;       // this block carries the length field
    logic [1:0]  r_widx, n_widx;

    t_core_cmd   cmd;
    t_core_sts   sts;
    t_hash       hash;
    logic        in_acc;
    logic [7:0]  len_byte;

    sha_bsh_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_hash  (hash)
    );

    assign in_acc = i_valid && o_ready;

    // Length bytes go out most significant first at block positions 56 to 63.
    assign len_byte = r_bits[{3'd7 - r_fill[2:0], 3'b000} +: 8];

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_bits    = r_bits;
        n_eom     = r_eom;
        n_mark    = r_mark;
        n_len     = r_len;
        n_widx    = r_widx;
        cmd       = '0;
        o_ready   = 1'b0;
        o_valid   = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                n_mark  = 1'b0;
                n_len   = 1'b0;
                if (in_acc) begin
                    if (i_has_byte) begin
                        cmd.shift = 1'b1;
                        cmd.data  = i_data_byte;
                        n_fill    = r_fill + 6'd1;
                        n_bits    = r_bits + 64'd8;
                    end
                    if (i_has_byte && r_fill == 6'd63) begin
                        // The byte completes a block: compress before anything else.
                        cmd.start = 1'b1;
                        n_eom     = i_end_of_message;
                        n_state   = S_COMP;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                cmd.shift = 1'b1;
                n_fill    = r_fill + 6'd1;
                if (!r_mark) begin
                    cmd.data = 8'h80;
                    n_mark   = 1'b1;
                    // The length fits behind the marker only below position 56.
                    if (r_fill[5:3] != 3'b111) begin
                        n_len = 1'b1;
                    end
                end else if (r_len && r_fill[5:3] == 3'b111) begin
                    cmd.data = len_byte;
                end else begin
                    cmd.data = 8'h00;
                end
                if (r_fill == 6'd63) begin
                    cmd.start = 1'b1;
                    n_state   = S_COMP;
                end
            end
            S_COMP: begin
                if (sts.done) begin
                    if (!r_mark) begin
                        n_state = r_eom ? S_PAD : S_IDLE;
                    end else if (r_len) begin
                        n_widx  = 2'd0;
                        n_state = S_OUT;
                    end else begin
                        // Marker block done; the next block holds zeros and the length.
                        n_len   = 1'b1;
                        n_state = S_PAD;
                    end
                end
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_widx = r_widx + 2'd1;
                    if (r_widx == 2'd3) begin
                        cmd.init = 1'b1;
                        n_bits   = 64'd0;
                        n_fill   = 6'd0;
                        n_eom    = 1'b0;
                        n_state  = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= 6'd0;
            r_bits  <= 64'd0;
            r_eom   <= 1'b0;
            r_mark  <= 1'b0;
            r_len   <= 1'b0;
            r_widx  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_bits  <= n_bits;
            r_eom   <= n_eom;
            r_mark  <= n_mark;
            r_len   <= n_len;
            r_widx  <= n_widx;
        end
    end

    // Digest word k is hash word 2k followed by hash word 2k+1.
    assign o_digest_word = {hash[{r_widx, 1'b0}], hash[{r_widx, 1'b1}]};
    assign o_word_index  = r_widx;
    assign o_digest_last = (r_widx == 2'd3);

`ifndef SYNTHESIS
    a_start_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start |-> (cmd.shift && r_fill == 6'd63 && !sts.busy))
        else $error("compression started without a full block");

    a_done_in_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.done |-> (r_state == S_COMP))
        else $error("compression finished outside the wait state");

    a_no_shift_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.busy |-> !cmd.shift)
        else $error("byte shifted into the block during compression");

    a_clean_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_digest_last) |=>
            (r_fill == 6'd0 && r_bits == 64'd0 && !o_valid && o_ready))
        else $error("state not cleared after the last digest word");
`endif

endmodule

// ===== hw/rtl/sha_bsh_core.sv =====
// SHA-256 compression unit: block register, schedule window, one round per cycle.
// Depends on sha_bsh_pkg.
module sha_bsh_core
    import sha_bsh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_core_cmd i_cmd,
    output t_core_sts o_sts,
    output t_hash     o_hash
);

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROUND,
        C_FOLD
    } t_cstate;

    t_cstate     r_state, n_state;
    logic [5:0]  r_round, n_round;
    logic        r_done, n_done;
    logic [511:0] r_blk, n_blk;
    t_hash       r_hash, n_hash;
    t_hash       r_v, n_v;

    logic [31:0] w0, w1, w9, w14, sig0, sig1, new_w;
    logic [31:0] big0, big1, chs, maj, t1, t2;

    function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
        return (x >> n) | (x << (6'd32 - {1'b0, n}));
    endfunction

    // The block register doubles as the 16-word schedule window; word 0 is at the top.
    assign w0  = r_blk[511:480];
    assign w1  = r_blk[479:448];
    assign w9  = r_blk[223:192];
    assign w14 = r_blk[63:32];

    assign sig0  = rotr(w1, 5'd7) ^ rotr(w1, 5'd18) ^ (w1 >> 3);
    assign sig1  = rotr(w14, 5'd17) ^ rotr(w14, 5'd19) ^ (w14 >> 10);
    assign new_w = sig1 + w9 + sig0 + w0;

    assign big1 = rotr(r_v[4], 5'd6) ^ rotr(r_v[4], 5'd11) ^ rotr(r_v[4], 5'd25);
    assign chs  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign t1   = r_v[7] + big1 + chs + SHA_K[r_round] + w0;
    assign big0 = rotr(r_v[0], 5'd2) ^ rotr(r_v[0], 5'd13) ^ rotr(r_v[0], 5'd22);
    assign maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t2   = big0 + maj;

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_done  = 1'b0;
        n_blk   = r_blk;
        n_hash  = r_hash;
        n_v     = r_v;

        if (i_cmd.shift) begin
            n_blk = {r_blk[503:0], i_cmd.data};
        end else if (r_state == C_ROUND) begin
            n_blk = {r_blk[479:0], new_w};
        end

        if (i_cmd.init) begin
            for (int i = 0; i < 8; i++) begin
                n_hash[i] = SHA_H0[i];
            end
        end

        case (r_state)
            C_IDLE: begin
                if (i_cmd.start) begin
                    n_v     = r_hash;
                    n_round = 6'd0;
                    n_state = C_ROUND;
                end
            end
            C_ROUND: begin
                n_v[7]  = r_v[6];
                n_v[6]  = r_v[5];
                n_v[5]  = r_v[4];
                n_v[4]  = r_v[3] + t1;
                n_v[3]  = r_v[2];
                n_v[2]  = r_v[1];
                n_v[1]  = r_v[0];
                n_v[0]  = t1 + t2;
                n_round = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    n_state = C_FOLD;
                end
            end
            C_FOLD: begin
                for (int i = 0; i < 8; i++) begin
                    n_hash[i] = r_hash[i] + r_v[i];
                end
                n_done  = 1'b1;
                n_state = C_IDLE;
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_round <= 6'd0;
            r_done  <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= SHA_H0[i];
            end
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_done  <= n_done;
            r_hash  <= n_hash;
        end
        r_blk <= n_blk;
        r_v   <= n_v;
    end

    assign o_sts.busy = (r_state != C_IDLE);
    assign o_sts.done = r_done;
    assign o_hash     = r_hash;

endmodule
